/* sv/rcfe_pkg.sv */
// Shared types, constants and the CRC-16 byte step for the relay command frame encoder.
// No dependencies; used by every module of the block.
`default_nettype none
package rcfe_pkg;

    localparam int BODY_MAX = 12;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] PAT_CLOSE  = 8'h55;
    localparam logic [7:0] PAT_OPEN   = 8'h33;
    localparam logic [7:0] LEN_SHORT  = 8'h05;
    localparam logic [7:0] LEN_LONG   = 8'h09;
    localparam logic [7:0] LEN_TIME   = 8'h0C;
    localparam logic [7:0] FN_SETPT   = 8'h08;
    localparam logic [7:0] FN_SETRD   = 8'h03;
    localparam logic [7:0] FLAG_CLEAR = 8'hFF;

    localparam logic [3:0] BODY_SHORT = 4'd5;
    localparam logic [3:0] BODY_LONG  = 4'd9;
    localparam logic [3:0] BODY_TIME  = 4'd12;

    typedef enum logic [2:0] {
        REQ_POLL    = 3'd0,
        REQ_SETRD   = 3'd1,
        REQ_SETPT   = 3'd2,
        REQ_CONTROL = 3'd3,
        REQ_TIME    = 3'd4,
        REQ_EVENT   = 3'd5
    } t_req;

    typedef struct packed {
        logic [3:0]                body_len;
        logic [BODY_MAX-1:0][7:0]  body;
    } t_frame;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/relay_command_frame_encoder_core.sv */
// Top level of the relay command frame encoder: address register, front end, queue, back end.
// Depends on rcfe_pkg, rcfe_front, rcfe_queue, rcfe_back.
//
//   channel   direction  handshake              payload
//   in        input      i_in_valid/o_in_stall  i_req_type .. i_second
//   out       output     o_out_valid/i_out_stall o_tx_byte, o_frame_end
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (device address)
//
// A request transfer is accepted whenever the two-entry queue has room.
// The back end sends one byte per cycle while the output is not stalled; for each frame it
// first loads the frame from the queue, then sends its body bytes and the two CRC bytes.
// Reset is synchronous: it empties the queue, clears the event flag and the address.
// A stalled output holds its byte; the queue absorbs up to two frames meanwhile.
`default_nettype none
module relay_command_frame_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_func_code,
    input  wire logic [7:0]  i_point_addr,
    input  wire logic [15:0] i_value_word,
    input  wire logic        i_switch_on,
    input  wire logic [6:0]  i_year_of_century,
    input  wire logic [3:0]  i_month,
    input  wire logic [4:0]  i_day,
    input  wire logic [4:0]  i_hour,
    input  wire logic [5:0]  i_minute,
    input  wire logic [5:0]  i_second,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_tx_byte,
    output logic             o_frame_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0]       r_device_address;
    logic             w_fire;
    logic             w_push;
    logic             w_pending;
    logic             w_q_valid;
    logic             w_q_full;
    logic             w_q_pop;
    rcfe_pkg::t_frame w_front_frame;
    rcfe_pkg::t_frame w_q_frame;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_full;
    assign w_fire      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_address <= i_cfg_data;
        end
    end

    rcfe_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_fire),
        .i_device_address  (r_device_address),
        .i_req_type        (i_req_type),
        .i_func_code       (i_func_code),
        .i_point_addr      (i_point_addr),
        .i_value_word      (i_value_word),
        .i_switch_on       (i_switch_on),
        .i_year_of_century (i_year_of_century),
        .i_month           (i_month),
        .i_day             (i_day),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second          (i_second),
        .o_push            (w_push),
        .o_frame           (w_front_frame),
        .o_pending         (w_pending)
    );

    rcfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_front_frame),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_frame (w_q_frame)
    );

    rcfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_frame   (w_q_frame),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("frame pushed into a full queue");

    a_event_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_req_type == rcfe_pkg::REQ_EVENT) |=> w_pending)
        else $error("event request did not arm the clear flag");

    a_poll_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_req_type == rcfe_pkg::REQ_POLL) |=> !w_pending)
        else $error("poll request did not clear the flag");
`endif

endmodule
`default_nettype wire

/* sv/rcfe_front.sv */
// Front end: classifies accepted requests, keeps the clear-events flag and builds frame bodies.
// Depends on rcfe_pkg.
`default_nettype none
module rcfe_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [7:0]           i_device_address,
    input  wire logic [2:0]           i_req_type,
    input  wire logic [7:0]           i_func_code,
    input  wire logic [7:0]           i_point_addr,
    input  wire logic [15:0]          i_value_word,
    input  wire logic                 i_switch_on,
    input  wire logic [6:0]           i_year_of_century,
    input  wire logic [3:0]           i_month,
    input  wire logic [4:0]           i_day,
    input  wire logic [4:0]           i_hour,
    input  wire logic [5:0]           i_minute,
    input  wire logic [5:0]           i_second,
    output logic                      o_push,
    output rcfe_pkg::t_frame          o_frame,
    output logic                      o_pending
);

    logic r_pending;
    logic n_pending;
    logic [7:0] w_pat;

    always_comb begin
        w_pat = (i_point_addr == 8'h00) ? 8'h00
              : (i_switch_on ? rcfe_pkg::PAT_CLOSE : rcfe_pkg::PAT_OPEN);
        o_frame   = '0;
        o_frame.body[0] = i_device_address;
        o_push    = 1'b0;
        n_pending = r_pending;
        case (i_req_type)
            rcfe_pkg::REQ_POLL: begin
                o_frame.body[2]  = rcfe_pkg::LEN_SHORT;
                o_frame.body[3]  = i_func_code;
                o_frame.body[4]  = r_pending ? rcfe_pkg::FLAG_CLEAR : 8'h00;
                o_frame.body_len = rcfe_pkg::BODY_SHORT;
                o_push = i_fire;
                if (i_fire) begin
                    n_pending = 1'b0;
                end
            end
            rcfe_pkg::REQ_SETRD: begin
                o_frame.body[2]  = rcfe_pkg::LEN_SHORT;
                o_frame.body[3]  = rcfe_pkg::FN_SETRD;
                o_frame.body_len = rcfe_pkg::BODY_SHORT;
                o_push = i_fire;
            end
            rcfe_pkg::REQ_SETPT: begin
                o_frame.body[2]  = rcfe_pkg::LEN_LONG;
                o_frame.body[3]  = rcfe_pkg::FN_SETPT;
                o_frame.body[4]  = i_point_addr;
                o_frame.body[5]  = i_value_word[15:8];
                o_frame.body[6]  = i_value_word[7:0];
                o_frame.body_len = rcfe_pkg::BODY_LONG;
                o_push = i_fire;
            end
            rcfe_pkg::REQ_CONTROL: begin
                o_frame.body[2]  = rcfe_pkg::LEN_LONG;
                o_frame.body[3]  = i_func_code;
                o_frame.body[4]  = i_point_addr;
                o_frame.body[5]  = w_pat;
                o_frame.body[6]  = w_pat;
                o_frame.body[7]  = w_pat;
                o_frame.body[8]  = w_pat;
                o_frame.body_len = rcfe_pkg::BODY_LONG;
                o_push = i_fire;
            end
            rcfe_pkg::REQ_TIME: begin
                o_frame.body[2]  = rcfe_pkg::LEN_TIME;
                o_frame.body[4]  = {1'b0, i_year_of_century};
                o_frame.body[5]  = {4'h0, i_month};
                o_frame.body[6]  = {3'h0, i_day};
                o_frame.body[7]  = {3'h0, i_hour};
                o_frame.body[8]  = {2'h0, i_minute};
                o_frame.body[9]  = {2'h0, i_second};
                o_frame.body_len = rcfe_pkg::BODY_TIME;
                o_push = i_fire;
            end
            rcfe_pkg::REQ_EVENT: begin
                if (i_fire) begin
                    n_pending = 1'b1;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
    end

    assign o_pending = r_pending;

endmodule
`default_nettype wire

/* sv/rcfe_queue.sv */
// Two-entry frame queue between the front end and the byte sequencer.
// Depends on rcfe_pkg.
`default_nettype none
module rcfe_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire rcfe_pkg::t_frame     i_frame,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output logic                      o_full,
    output rcfe_pkg::t_frame          o_frame
);

    rcfe_pkg::t_frame r_mem [rcfe_pkg::QDEPTH];
    logic [rcfe_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [rcfe_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [rcfe_pkg::QCNT_W-1:0] r_count;
    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == rcfe_pkg::QCNT_W'(rcfe_pkg::QDEPTH));
    assign o_valid   = (r_count != '0);
    assign o_frame   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/rcfe_back.sv */
// Back end: sends frame bytes one per transfer and appends the CRC-16, low byte first.
// Depends on rcfe_pkg.
`default_nettype none
module rcfe_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire rcfe_pkg::t_frame     i_q_frame,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_tx_byte,
    output logic                      o_frame_end
);

    rcfe_pkg::t_frame r_frame;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_tx_byte;
    logic        r_frame_end;

    logic        w_emit;
    logic        w_in_body;
    logic        w_last;
    logic [7:0]  w_byte;
    logic [15:0] n_crc;

    assign o_q_pop   = !r_busy && i_q_valid;
    assign w_emit    = r_busy && (!r_out_valid || !i_out_stall);
    assign w_in_body = (r_idx < r_frame.body_len);
    assign w_last    = (r_idx == r_frame.body_len + 4'd1);

    always_comb begin
        n_crc = r_crc;
        if (w_in_body) begin
            w_byte = r_frame.body[r_idx];
            n_crc  = rcfe_pkg::crc_byte(r_crc, w_byte);
        end else if (w_last) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = r_crc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_frame <= i_q_frame;
        end
        if (w_emit) begin
            r_tx_byte   <= w_byte;
            r_frame_end <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_crc       <= rcfe_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_crc  <= rcfe_pkg::CRC_INIT;
            end else if (w_emit) begin
                r_idx <= r_idx + 4'd1;
                r_crc <= n_crc;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_frame_end = r_frame_end;

endmodule
`default_nettype wire
